FILE: design/psb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_pkg
// Shared constants, types and helper functions of the section builder.
// ----------------------------------------------------------------------------
package psb_pkg;

    localparam int CMD_W  = 3;
    localparam int NUM_W  = 3;
    localparam int IDX_W  = 12;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int FILL_W = 13;
    localparam int CAP_W  = 13;
    localparam int CRC_W  = 32;
    localparam int EXT_W  = 18;

    typedef logic [7:0] t_byte;

    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PATCH_B = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PATCH_H = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FINISH  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_OVF   = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET   = 13'd1024;
    localparam logic [CRC_W-1:0] CRC_POLY    = 32'h04C11DB7;
    localparam logic [CRC_W-1:0] CRC_INIT    = 32'hFFFFFFFF;
    localparam t_byte            BYTE_ERASED = 8'hFF;
    localparam logic [NUM_W-1:0] MAX_APPEND  = 3'd4;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input t_byte data);
        logic [CRC_W-1:0] acc;
        acc = crc ^ {data, 24'd0};
        for (int b = 0; b < 8; b++) begin
            acc = acc[CRC_W-1] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
        end
        return acc;
    endfunction

    function automatic t_byte pick_byte(input logic [VAL_W-1:0] word,
                                        input logic [1:0] sel);
        t_byte b;
        case (sel)
            2'd0: b = word[7:0];
            2'd1: b = word[15:8];
            2'd2: b = word[23:16];
            2'd3: b = word[31:24];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

endpackage

FILE: design/psb_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_req_if
// Command channel of the section builder: valid, ready and command fields.
// ----------------------------------------------------------------------------
interface psb_req_if import psb_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [NUM_W-1:0] num_bytes;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;

    modport source (output valid, cmd, num_bytes, index, value, input ready);
    modport sink   (input valid, cmd, num_bytes, index, value, output ready);
endinterface

FILE: design/psb_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_rsp_if
// Result channel of the section builder: valid, ready and result fields.
// ----------------------------------------------------------------------------
interface psb_rsp_if import psb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [FILL_W-1:0] fill_count;
    t_byte             read_byte;
    logic [CRC_W-1:0]  crc_value;

    modport source (output valid, status, fill_count, read_byte, crc_value, input ready);
    modport sink   (input valid, status, fill_count, read_byte, crc_value, output ready);
endinterface

FILE: design/psb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module psb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: design/psi_section_builder_crc32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psi_section_builder_crc32
// Builds a table section in a byte RAM and appends its CRC-32/MPEG-2.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  i_req     in         cmd, num_bytes, index, value
//  o_rsp     out        status, fill_count, read_byte, crc_value
//  i_cfg_*   in         section_capacity write
//
//  One command is worked on at a time through the single byte RAM port pair.
//  Append and patch halfword write their later bytes in S_WRITE; read waits on the
//  registered RAM read; finish runs the CRC over the filled bytes, then appends it;
//  clear erases the RAM. After reset a clearing pass fills the RAM with 0xFF
//  before the first transaction is accepted.
//  A waiting result holds off the next command unless it is taken in the same cycle.
// ----------------------------------------------------------------------------
module psi_section_builder_crc32 import psb_pkg::*; #(
    parameter int SECTION_BYTES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data,
    psb_req_if.sink          i_req,
    psb_rsp_if.source        o_rsp
);
    localparam int AW = $clog2(SECTION_BYTES);
    localparam int PW = AW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_CRC   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CAP_W-1:0]  r_capacity;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [CRC_W-1:0]  r_last_crc, n_last_crc;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [PW-1:0]     r_ptr, n_ptr;
    logic              r_pend, n_pend;
    logic              r_clr_rsp, n_clr_rsp;
    logic [VAL_W-1:0]  r_wbuf, n_wbuf;
    logic [NUM_W-1:0]  r_wcnt, n_wcnt;
    logic [AW-1:0]     r_waddr, n_waddr;

    logic              r_o_valid;
    logic [ST_W-1:0]   r_o_status;
    logic [FILL_W-1:0] r_o_fill;
    t_byte             r_o_rbyte;
    logic [CRC_W-1:0]  r_o_crc;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_byte             mem_wdata;
    logic [AW-1:0]     mem_raddr;
    t_byte             mem_rdata;

    logic              accept;
    logic              done;
    logic [ST_W-1:0]   d_status;
    t_byte             d_rbyte;

    logic [EXT_W-1:0]  w_cap;
    logic [EXT_W-1:0]  w_fill_x;
    logic [EXT_W-1:0]  w_idx_x;
    logic [EXT_W-1:0]  w_idx1_x;
    logic [EXT_W-1:0]  w_fill1_x;
    logic [NUM_W-1:0]  w_n;
    logic              w_rd_en;
    logic [CRC_W-1:0]  w_crc_next;

    psb_ram #(
        .WIDTH (8),
        .DEPTH (SECTION_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE) && (!r_o_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    assign w_cap     = (EXT_W'(r_capacity) > EXT_W'(SECTION_BYTES)) ?
                       EXT_W'(SECTION_BYTES) : EXT_W'(r_capacity);
    assign w_fill_x  = EXT_W'(r_fill);
    assign w_fill1_x = w_fill_x + EXT_W'(1);
    assign w_idx_x   = EXT_W'(i_req.index);
    assign w_idx1_x  = w_idx_x + EXT_W'(1);
    assign w_n       = (i_req.num_bytes > MAX_APPEND) ? MAX_APPEND : i_req.num_bytes;
    assign w_rd_en   = EXT_W'(r_ptr) < w_fill_x;
    assign w_crc_next = r_pend ? crc_byte(r_crc, mem_rdata) : r_crc;

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_last_crc = r_last_crc;
        n_crc      = r_crc;
        n_ptr      = r_ptr;
        n_pend     = 1'b0;
        n_clr_rsp  = r_clr_rsp;
        n_wbuf     = r_wbuf;
        n_wcnt     = r_wcnt;
        n_waddr    = r_waddr;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = '0;
        done       = 1'b0;
        d_status   = ST_OK;
        d_rbyte    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.cmd)
                        CMD_APPEND: begin
                            if (w_fill_x + EXT_W'(w_n) > w_cap) begin
                                d_status = ST_OVF;
                                done     = 1'b1;
                            end else if (w_n == '0) begin
                                done = 1'b1;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = w_fill_x[AW-1:0];
                                mem_wdata = pick_byte(i_req.value, 2'(w_n - 3'd1));
                                n_fill    = r_fill + FILL_W'(w_n);
                                if (w_n == 3'd1) begin
                                    done = 1'b1;
                                end else begin
                                    n_wbuf  = i_req.value;
                                    n_wcnt  = w_n - 3'd1;
                                    n_waddr = w_fill1_x[AW-1:0];
                                    n_state = S_WRITE;
                                end
                            end
                        end
                        CMD_PATCH_B: begin
                            if (w_idx_x >= w_cap) begin
                                d_status = ST_RANGE;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = w_idx_x[AW-1:0];
                                mem_wdata = i_req.value[7:0];
                            end
                            done = 1'b1;
                        end
                        CMD_PATCH_H: begin
                            if (w_idx1_x >= w_cap) begin
                                d_status = ST_RANGE;
                                done     = 1'b1;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = w_idx_x[AW-1:0];
                                mem_wdata = i_req.value[15:8];
                                n_wbuf    = i_req.value;
                                n_wcnt    = 3'd1;
                                n_waddr   = w_idx1_x[AW-1:0];
                                n_state   = S_WRITE;
                            end
                        end
                        CMD_FINISH: begin
                            if (w_fill_x + EXT_W'(4) > w_cap) begin
                                d_status = ST_OVF;
                                done     = 1'b1;
                            end else begin
                                n_ptr   = '0;
                                n_crc   = CRC_INIT;
                                n_state = S_CRC;
                            end
                        end
                        CMD_READ: begin
                            if (w_idx_x >= w_cap) begin
                                d_status = ST_RANGE;
                                done     = 1'b1;
                            end else begin
                                mem_raddr = w_idx_x[AW-1:0];
                                n_state   = S_READ;
                            end
                        end
                        CMD_CLEAR: begin
                            n_fill    = '0;
                            n_ptr     = '0;
                            n_clr_rsp = 1'b1;
                            n_state   = S_CLEAR;
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = r_waddr;
                mem_wdata = pick_byte(r_wbuf, 2'(r_wcnt - 3'd1));
                n_waddr   = r_waddr + AW'(1);
                n_wcnt    = r_wcnt - 3'd1;
                if (r_wcnt == 3'd1) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CRC: begin
                mem_raddr = r_ptr[AW-1:0];
                n_crc     = w_crc_next;
                n_pend    = w_rd_en;
                if (w_rd_en) begin
                    n_ptr = r_ptr + PW'(1);
                end else begin
                    n_last_crc = w_crc_next;
                    n_wbuf     = w_crc_next;
                    n_wcnt     = MAX_APPEND;
                    n_waddr    = w_fill_x[AW-1:0];
                    n_fill     = r_fill + FILL_W'(4);
                    n_state    = S_WRITE;
                end
            end
            S_READ: begin
                d_rbyte = mem_rdata;
                done    = 1'b1;
                n_state = S_IDLE;
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[AW-1:0];
                mem_wdata = BYTE_ERASED;
                n_ptr     = r_ptr + PW'(1);
                if (r_ptr[AW-1:0] == AW'(SECTION_BYTES - 1)) begin
                    n_ptr     = '0;
                    n_clr_rsp = 1'b0;
                    done      = r_clr_rsp;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_capacity <= CAP_RESET;
            r_fill     <= '0;
            r_last_crc <= '0;
            r_ptr      <= '0;
            r_pend     <= 1'b0;
            r_clr_rsp  <= 1'b0;
            r_wcnt     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_last_crc <= n_last_crc;
            r_ptr     <= n_ptr;
            r_pend    <= n_pend;
            r_clr_rsp <= n_clr_rsp;
            r_wcnt    <= n_wcnt;
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (done) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc   <= n_crc;
        r_wbuf  <= n_wbuf;
        r_waddr <= n_waddr;
        if (done) begin
            r_o_status <= d_status;
            r_o_fill   <= n_fill;
            r_o_rbyte  <= d_rbyte;
            r_o_crc    <= n_last_crc;
        end
    end

    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.fill_count = r_o_fill;
    assign o_rsp.read_byte  = r_o_rbyte;
    assign o_rsp.crc_value  = r_o_crc;

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (r_state == S_IDLE))
        else $error("command ready outside idle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EXT_W'(r_fill) <= EXT_W'(SECTION_BYTES))
        else $error("fill length beyond store size");

    a_write_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_wcnt != '0))
        else $error("byte writer active with nothing left");

    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state != S_CRC) && (r_state != S_READ)))
        else $error("store written during a read sequence");

    a_pend_in_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_CRC))
        else $error("pending crc byte outside crc walk");
`endif
endmodule
